FILE: sv/mandelbrot_escape_count_core_macros.svh
// Assertion macros for the Mandelbrot escape-count core.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef MANDELBROT_ESCAPE_COUNT_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_COUNT_CORE_MACROS_SVH

// same-cycle implication
`define MEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication
`define MEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: sv/mec_pkg.sv
// Shared types and constants for the Mandelbrot escape-count core.
// No dependencies; used by mec_cell and mandelbrot_escape_count_core.
`default_nettype none

package mec_pkg;

    localparam int COORD_W = 32;
    localparam int COUNT_W = 16;
    localparam int THR_W   = 31;
    localparam int CFG_W   = 31;
    localparam int IDX_W   = 1;

    localparam int FRAC_BITS_DEF = 28;
    localparam int NUM_CELLS_DEF = 4;

    localparam logic [IDX_W-1:0] REG_MAX_ITER = 1'd0;
    localparam logic [IDX_W-1:0] REG_ESC_THR  = 1'd1;

    localparam logic [COUNT_W-1:0] MAX_ITER_RST = 16'd255;
    localparam logic [THR_W-1:0]   ESC_THR_RST  = 31'd1073741824;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [COUNT_W-1:0] max_iter;
        logic [THR_W-1:0]   esc_thr;
    } mec_cfg_t;

    typedef struct packed {
        logic                      valid;
        logic                      done;
        logic                      ovf;
        logic [COUNT_W-1:0]        k;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
    } mec_token_t;

endpackage

`default_nettype wire

FILE: sv/mec_cell.sv
// One iteration cell: product register, then escape test and z*z+c update.
// Depends on mec_pkg.
`default_nettype none

module mec_cell #(
    parameter int FRAC_BITS = mec_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mec_pkg::mec_cfg_t  cfg,
    input  wire mec_pkg::mec_token_t tok_in,
    output mec_pkg::mec_token_t     tok_out
);
    import mec_pkg::*;

    localparam int PROD_W = 2 * COORD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int LIM_W  = THR_W + FRAC_BITS;
    localparam int CMP_W  = (LIM_W > PROD_W) ? LIM_W : PROD_W;

    mec_token_t               tok_a_reg;
    logic signed [PROD_W-1:0] xx_reg, yy_reg, xy_reg;
    logic signed [PROD_W-1:0] xx_next, yy_next, xy_next;
    mec_token_t               tok_b_reg, tok_b_next;

    logic [PROD_W-1:0]        mag;
    logic [CMP_W-1:0]         mag_ext, lim;
    logic                     escaped;
    logic signed [PROD_W-1:0] diff, re_sh, im_sh;
    logic signed [SUM_W-1:0]  re_sum, im_sum;
    logic                     ovf_re, ovf_im;
    logic signed [COORD_W-1:0] x_sat, y_sat;

    // stage A: squares and cross product
    always_comb
    begin
        xx_next = $signed(tok_in.x) * $signed(tok_in.x);
        yy_next = $signed(tok_in.y) * $signed(tok_in.y);
        xy_next = $signed(tok_in.x) * $signed(tok_in.y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg <= '0;
        end
        else
        begin
            tok_a_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg <= xx_next;
        yy_reg <= yy_next;
        xy_reg <= xy_next;
    end

    // stage B: escape test and update
    always_comb
    begin
        mag     = $unsigned(xx_reg) + $unsigned(yy_reg);
        mag_ext = CMP_W'(mag);
        lim     = CMP_W'(cfg.esc_thr) << FRAC_BITS;
        escaped = mag_ext > lim;

        diff  = xx_reg - yy_reg;
        re_sh = diff >>> FRAC_BITS;
        im_sh = xy_reg >>> (FRAC_BITS - 1);

        re_sum = {re_sh[PROD_W-1], re_sh}
               + {{(SUM_W-COORD_W){tok_a_reg.a[COORD_W-1]}}, tok_a_reg.a};
        im_sum = {im_sh[PROD_W-1], im_sh}
               + {{(SUM_W-COORD_W){tok_a_reg.b[COORD_W-1]}}, tok_a_reg.b};

        ovf_re = !((&re_sum[SUM_W-1:COORD_W-1]) || !(|re_sum[SUM_W-1:COORD_W-1]));
        ovf_im = !((&im_sum[SUM_W-1:COORD_W-1]) || !(|im_sum[SUM_W-1:COORD_W-1]));

        if (ovf_re)
            x_sat = re_sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
        else
            x_sat = re_sum[COORD_W-1:0];

        if (ovf_im)
            y_sat = im_sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
        else
            y_sat = im_sum[COORD_W-1:0];

        tok_b_next = tok_a_reg;
        if (tok_a_reg.valid && !tok_a_reg.done)
        begin
            if ((tok_a_reg.k >= cfg.max_iter) || tok_a_reg.ovf || escaped)
            begin
                tok_b_next.done = 1'b1;
            end
            else
            begin
                tok_b_next.x   = x_sat;
                tok_b_next.y   = y_sat;
                tok_b_next.ovf = ovf_re || ovf_im;
                tok_b_next.k   = tok_a_reg.k + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_b_reg <= '0;
        end
        else
        begin
            tok_b_reg <= tok_b_next;
        end
    end

    assign tok_out = tok_b_reg;

endmodule

`default_nettype wire

FILE: sv/mandelbrot_escape_count_core.sv
// Channel | dir | payload                                  | transaction when
// s_      | in  | tdata: coord_re[31:0], coord_im[63:32]   | s_tvalid & s_tready
// m_      | out | tdata: escape_count[15:0]                | m_tvalid & m_tready
// cfg_    | in  | index 0 max_iterations, 1 escape_threshold | cfg_we
// One point circulates through a ring of NUM_CELLS cells; each cell does one
// iteration in its product register and then its update register.
// Next point is taken once the previous count moves to the output register.
// A stalled output holds the finished point in the ring. Reset clears all valid bits.
// Depends on mec_pkg, mec_cell and mandelbrot_escape_count_core_macros.svh.
`default_nettype none
`include "mandelbrot_escape_count_core_macros.svh"

module mandelbrot_escape_count_core #(
    parameter int FRAC_BITS = mec_pkg::FRAC_BITS_DEF,
    parameter int NUM_CELLS = mec_pkg::NUM_CELLS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [2*mec_pkg::COORD_W-1:0] s_tdata,  // coord_re, coord_im
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [mec_pkg::COUNT_W-1:0]      m_tdata,   // escape_count
    input  wire logic                        cfg_we,
    input  wire logic [mec_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [mec_pkg::CFG_W-1:0]   cfg_wdata
);
    import mec_pkg::*;

    logic [COUNT_W-1:0] max_iter_reg;
    logic [THR_W-1:0]   esc_thr_reg;
    mec_cfg_t           cfg;

    logic               busy_reg, busy_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W-1:0] count_reg;

    mec_token_t         cell_in  [NUM_CELLS];
    mec_token_t         cell_out [NUM_CELLS];
    mec_token_t         ring_in, last;
    logic               accept, capture;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RST;
            esc_thr_reg  <= ESC_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_ITER: max_iter_reg <= cfg_wdata[COUNT_W-1:0];
                REG_ESC_THR:  esc_thr_reg  <= cfg_wdata[THR_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg.max_iter = max_iter_reg;
    assign cfg.esc_thr  = esc_thr_reg;

    assign last     = cell_out[NUM_CELLS-1];
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && !busy_reg;
    assign capture  = last.valid && last.done && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        ring_in = '0;
        if (accept)
        begin
            ring_in.valid = 1'b1;
            ring_in.x     = s_tdata[COORD_W-1:0];
            ring_in.a     = s_tdata[COORD_W-1:0];
            ring_in.y     = s_tdata[2*COORD_W-1:COORD_W];
            ring_in.b     = s_tdata[2*COORD_W-1:COORD_W];
        end
        else if (last.valid && !capture)
        begin
            ring_in = last;
        end

        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (capture)
            busy_next = 1'b0;

        m_tvalid_next = m_tvalid_reg;
        if (capture)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    generate
        for (genvar i = 0; i < NUM_CELLS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign cell_in[i] = ring_in;
            end
            else
            begin : g_link
                assign cell_in[i] = cell_out[i-1];
            end

            mec_cell #(
                .FRAC_BITS (FRAC_BITS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cfg     (cfg),
                .tok_in  (cell_in[i]),
                .tok_out (cell_out[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
            count_reg <= last.k;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = count_reg;

    `MEC_ASSERT_NOW(a_capture_busy, capture, busy_reg)
    `MEC_ASSERT_NOW(a_idle_ring_empty, !busy_reg, !last.valid)
    `MEC_ASSERT_NEXT(a_accept_blocks, accept, !s_tready)
    `MEC_ASSERT_NOW(a_count_limit, last.valid && last.done, last.k <= max_iter_reg)

endmodule

`default_nettype wire

FILE: bench/mandelbrot_escape_count_core_checker.sv
`timescale 1ns / 1ps
// Scoreboard for mandelbrot_escape_count_core: tracks the config writes, predicts the
// escape count of every accepted point and checks the returned counts in order.
// Depends on mec_pkg.
module mandelbrot_escape_count_core_checker #(
    parameter int FRAC_BITS = mec_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [2*mec_pkg::COORD_W-1:0]     s_tdata,   // coord_re, coord_im
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [mec_pkg::COUNT_W-1:0]       m_tdata,   // escape_count
    input  logic                              cfg_we,
    input  logic [mec_pkg::IDX_W-1:0]         cfg_index,
    input  logic [mec_pkg::CFG_W-1:0]         cfg_wdata,
    output int                                mismatch_count,
    output int                                points_in_flight
);
    import mec_pkg::*;

    logic [COUNT_W-1:0] iter_limit = MAX_ITER_RST;
    logic [THR_W-1:0]   mag_limit  = ESC_THR_RST;
    logic [COUNT_W-1:0] expected_counts[$];
    logic [COUNT_W-1:0] want;

    function automatic logic signed [63:0] clamp_coord(input logic signed [63:0] v,
                                                       inout logic ovf);
        if (v > SAT_MAX)
        begin
            ovf = 1'b1;
            return SAT_MAX;
        end
        if (v < SAT_MIN)
        begin
            ovf = 1'b1;
            return SAT_MIN;
        end
        return v;
    endfunction

    function automatic logic [COUNT_W-1:0] escape_iterations(
        input logic signed [COORD_W-1:0] c_re,
        input logic signed [COORD_W-1:0] c_im
    );
        logic signed [63:0] a, b, x, y, xx, yy, nx, ny;
        logic [63:0]        mag, limit;
        logic               ovf;
        int unsigned        k;
        a = c_re;
        b = c_im;
        x = a;
        y = b;
        ovf = 1'b0;
        limit = {33'd0, mag_limit} << FRAC_BITS;
        for (k = 0; k < iter_limit; k++)
        begin
            xx = x * x;
            yy = y * y;
            mag = $unsigned(xx) + $unsigned(yy);
            if (ovf || mag > limit)
                break;
            nx = ((xx - yy) >>> FRAC_BITS) + a;
            ny = ((x * y) >>> (FRAC_BITS - 1)) + b;
            x = clamp_coord(nx, ovf);
            y = clamp_coord(ny, ovf);
        end
        return k[COUNT_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            iter_limit = MAX_ITER_RST;
            mag_limit = ESC_THR_RST;
            expected_counts.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_ITER)
                    iter_limit = cfg_wdata[COUNT_W-1:0];
                else if (cfg_index == REG_ESC_THR)
                    mag_limit = cfg_wdata[THR_W-1:0];
            end
            if (s_tvalid && s_tready)
                expected_counts.push_back(escape_iterations(s_tdata[COORD_W-1:0],
                                                            s_tdata[2*COORD_W-1:COORD_W]));
            if (m_tvalid && m_tready)
            begin
                if (expected_counts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected escape_count %0d", $realtime, m_tdata);
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (m_tdata !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: escape_count expected %0d got %0d",
                                     $realtime, want, m_tdata);
                    end
                end
            end
        end
        points_in_flight = expected_counts.size();
    end

endmodule

FILE: bench/mandelbrot_escape_count_core_tb.sv
`timescale 1ns / 1ps
// Top of the escape-count testbench: drives points, register writes and output stalls
// into mandelbrot_escape_count_core and reports the verdict from the checker.
// Depends on mec_pkg, mandelbrot_escape_count_core and its checker.
module mandelbrot_escape_count_core_tb;
    import mec_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [2*COORD_W-1:0]   s_tdata = '0;      // coord_re, coord_im
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [COUNT_W-1:0]     m_tdata;           // escape_count
    logic                   cfg_we = 1'b0;
    logic [IDX_W-1:0]       cfg_index = REG_MAX_ITER;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    int mismatch_count;
    int points_in_flight;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    always #2 clk = ~clk;

    mandelbrot_escape_count_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mandelbrot_escape_count_core_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .mismatch_count   (mismatch_count),
        .points_in_flight (points_in_flight)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_stall_pct);

    task automatic drain_points();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (points_in_flight != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_settings(input logic [COUNT_W-1:0] iters,
                                 input logic [THR_W-1:0] thr);
        logic [CFG_W-COUNT_W-1:0] pad;
        pad = (CFG_W-COUNT_W)'($urandom);
        drain_points();
        cfg_we <= 1'b1;
        cfg_index <= REG_MAX_ITER;
        cfg_wdata <= {pad, iters};   // upper bits are don't-care for this register
        @(posedge clk);
        cfg_index <= REG_ESC_THR;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_point(input logic [COORD_W-1:0] re, input logic [COORD_W-1:0] im);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {im, re};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic logic [2*COORD_W-1:0] random_point();
        int sel;
        int re, im;
        sel = $urandom_range(99);
        if (sel < 65)
        begin
            // around the set: re in [-2.25, 0.75], im in [-1.5, 1.5]
            re = $urandom_range(0, 805306368) - 603979776;
            im = $urandom_range(0, 805306368) - 402653184;
        end
        else if (sel < 82)
        begin
            re = $urandom_range(0, 1610612736) - 805306368;
            im = $urandom_range(0, 1610612736) - 805306368;
        end
        else if (sel < 95)
        begin
            re = $urandom;
            im = $urandom;
        end
        else
        begin
            re = ($urandom_range(2) == 0) ? SAT_MIN : (($urandom_range(1) == 0) ? SAT_MAX : 0);
            im = ($urandom_range(2) == 0) ? SAT_MIN : (($urandom_range(1) == 0) ? SAT_MAX : 0);
        end
        return {im[COORD_W-1:0], re[COORD_W-1:0]};
    endfunction

    initial
    begin
        logic [2*COORD_W-1:0] pt;
        logic [COUNT_W-1:0]   iters;
        logic [THR_W-1:0]     thr;
        int                   wait_cycles;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: limit 255, threshold 4.0
        load_settings(MAX_ITER_RST, ESC_THR_RST);
        send_point(32'h0000_0000, 32'h0000_0000);     // origin, bounded
        send_point(SAT_MAX, SAT_MAX);
        send_point(SAT_MIN, SAT_MIN);                 // squared sum reaches 2^63
        send_point(SAT_MIN, 32'h0000_0000);
        send_point(32'hE000_0000, 32'h0000_0000);     // -2.0 sits exactly on the threshold
        send_point(32'h2000_0000, 32'h0000_0000);     // 2.0 on the threshold, escapes next
        send_point(32'hE000_0000, 32'h0000_0001);     // just past the threshold
        send_point(32'h0400_0000, 32'h0000_0000);     // cusp at 0.25
        send_point(32'hF400_0000, 32'h0199_999A);     // -0.75 + 0.1i, slow escape
        send_point(32'h1000_0000, 32'h1000_0000);

        // widest threshold: escape through saturation, or at once for the corner point
        load_settings(MAX_ITER_RST, 31'h7FFF_FFFF);
        send_point(32'h2CCC_CCCD, 32'h0000_0000);     // real part saturates
        send_point(32'h1E66_6666, 32'h1E66_6666);     // imaginary part saturates high
        send_point(32'h1E66_6666, 32'hE199_999A);     // imaginary part saturates low
        send_point(SAT_MIN, SAT_MAX);

        // zero threshold
        load_settings(16'd7, 31'd0);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h0000_0001, 32'h0000_0000);
        send_point(32'h0000_0000, 32'hFFFF_FFFF);

        // zero limit
        load_settings(16'd0, ESC_THR_RST);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(SAT_MAX, 32'h0000_0000);

        load_settings(16'd1, ESC_THR_RST);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h3000_0000, 32'h0000_0000);

        // largest limit, one bounded point
        load_settings(16'hFFFF, ESC_THR_RST);
        send_point(32'h0000_0000, 32'h0000_0000);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    iters = 16'd64;
                    thr = ESC_THR_RST;
                end
                1:
                begin
                    iters = COUNT_W'($urandom_range(1, 64));
                    thr = THR_W'($urandom_range(0, 32'h7FFF_FFFF));
                end
                2:
                begin
                    iters = 16'd1;
                    thr = ESC_THR_RST;
                end
                3:
                begin
                    iters = 16'd2;
                    thr = 31'h1000_0000;
                end
                4:
                begin
                    iters = 16'd32;
                    thr = 31'h7FFF_FFFF;
                end
                5:
                begin
                    iters = 16'd48;
                    thr = 31'd0;
                end
                6:
                begin
                    iters = COUNT_W'($urandom_range(1, 64));
                    thr = THR_W'($urandom_range(0, 32'h4000_0000));
                end
                default:
                begin
                    iters = 16'd64;
                    thr = ESC_THR_RST;
                end
            endcase
            load_settings(iters, thr);
            case (phase % 4)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 52;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 52;
                end
                default:
                begin
                    tx_idle_pct = 28;
                    rx_stall_pct = 28;
                end
            endcase
            for (int n = 0; n < 100; n++)
            begin
                if ($urandom_range(39) == 0)
                    drain_points();
                pt = random_point();
                send_point(pt[COORD_W-1:0], pt[2*COORD_W-1:COORD_W]);
            end
        end

        s_tvalid <= 1'b0;
        wait_cycles = 0;
        do
        begin
            @(posedge clk);
            wait_cycles++;
        end
        while (points_in_flight != 0 && wait_cycles < 200000);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && points_in_flight == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/mec_pkg.sv
sv/mec_cell.sv
sv/mandelbrot_escape_count_core.sv
bench/mandelbrot_escape_count_core_checker.sv
bench/mandelbrot_escape_count_core_tb.sv
